/* rtl/hrp_pkg.sv */
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, constants and the hex digit decoder shared by the parser modules.
// ----------------------------------------------------------------------------
package hrp_pkg;

	// Record layout: length (2 chars), address (4), type (2), then data.
	localparam logic [9:0] POS_MAX    = 10'd1023;
	localparam logic [9:0] DATA_START = 10'd8;

	// ASCII codes used by the digit decoder.
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_UC_A  = 8'h41;
	localparam logic [7:0] ASCII_UC_F  = 8'h46;
	localparam logic [7:0] ASCII_LC_A  = 8'h61;
	localparam logic [7:0] ASCII_LC_F  = 8'h66;
	localparam logic [7:0] DIGIT_TEN   = 8'h0A;

	// Result kinds.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Input word: one character of the record.
	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} hrp_in_t;

	// Output word: a data word or a record-done report.
	typedef struct packed {
		logic        kind;
		logic [15:0] word_address;
		logic [31:0] word_data;
		logic [7:0]  record_type;
		logic [7:0]  data_length;
		logic        checksum_ok;
	} hrp_out_t;

	// What the back end does with a character.
	typedef enum logic [1:0] {
		OP_HEADER,
		OP_DATA,
		OP_CK_HIGH,
		OP_CK_LOW
	} hrp_op_e_t;

	// One classified character as it travels through the queue.
	typedef struct packed {
		hrp_op_e_t  op;
		logic [2:0] pidx;
		logic [3:0] digit;
		logic       restart;
	} hrp_cmd_t;

	// Case-insensitive hex decode; anything else reads as zero.
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'h00;
			if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
				d = c - ASCII_ZERO;
			end else if (c >= ASCII_UC_A && c <= ASCII_UC_F) begin
				d = c - ASCII_UC_A + DIGIT_TEN;
			end else if (c >= ASCII_LC_A && c <= ASCII_LC_F) begin
				d = c - ASCII_LC_A + DIGIT_TEN;
			end
			return d[3:0];
		end
	endfunction

endpackage

/* rtl/hex_record_parser.sv */
// ----------------------------------------------------------------------------
// hex_record_parser
// Parses the characters of one Intel HEX record into data words and a
// record-done report.
// ----------------------------------------------------------------------------
// Characters enter one per cycle while char_stall is low. The front end
// classifies each character by its position and writes it into a short command
// queue; the back end executes one command per cycle while no pending result is
// stalled by res_stall, and holds a result in an output register. With the
// queue empty, the character that completes a result passes through the command
// queue and then the output register before the result is presented. The queue
// depth (QUEUE_DEPTH) sets how long the result side may stall before char_stall
// rises. Every complete group of eight data characters yields a big-endian data
// word at word address (address >> 2) + word number; after the checksum a
// record-done word reports type, length and checksum status.
module hex_record_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  hrp_pkg::hrp_in_t  char_word,
	output logic              res_valid,
	input  logic              res_stall,
	output hrp_pkg::hrp_out_t res_word
);
	import hrp_pkg::*;

	hrp_cmd_t push_cmd;
	hrp_cmd_t pop_cmd;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;

	assign char_stall = full;

	// Front end: position tracking and classification.
	hrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_word  (char_word),
		.queue_full (full),
		.push       (push),
		.cmd        (push_cmd)
	);

	// Command queue between the two halves.
	hrp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.empty     (empty)
	);

	// Back end: field assembly, checksum and results.
	hrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!empty),
		.cmd       (pop_cmd),
		.pop       (pop),
		.res_valid (res_valid),
		.res_word  (res_word),
		.res_stall (res_stall)
	);

endmodule

/* rtl/hrp_front.sv */
// ----------------------------------------------------------------------------
// hrp_front
// Tracks the character position and the length field, decodes each character
// and classifies it into a command for the back end.
// ----------------------------------------------------------------------------
module hrp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	input  hrp_pkg::hrp_in_t char_word,
	input  logic             queue_full,
	output logic             push,
	output hrp_pkg::hrp_cmd_t cmd
);
	import hrp_pkg::*;

	logic [9:0] pos_q;
	logic [7:0] len_q;
	logic [3:0] len_hi_q;
	logic [9:0] p;
	logic [9:0] rec_end;
	logic [3:0] digit;
	logic       accept;
	logic       active;

	assign accept  = char_valid && !queue_full;
	assign p       = char_word.start_req ? 10'd0 : pos_q;
	assign digit   = hex_digit(char_word.ch);
	assign rec_end = DATA_START + {1'b0, len_q, 1'b0};

	// Classify the character by its place in the record.
	always_comb begin
		cmd.op      = OP_HEADER;
		cmd.pidx    = p[2:0];
		cmd.digit   = digit;
		cmd.restart = char_word.start_req;
		active      = 1'b1;
		if (p < DATA_START) begin
			cmd.op = OP_HEADER;
		end else if (p < rec_end) begin
			cmd.op = OP_DATA;
		end else if (p == rec_end) begin
			cmd.op = OP_CK_HIGH;
		end else if (p == rec_end + 10'd1) begin
			cmd.op = OP_CK_LOW;
		end else begin
			active = 1'b0;
		end
	end

	// Characters past the checksum are taken but leave nothing to do.
	assign push = accept && active;

	// Position counter and a local copy of the length field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			len_hi_q <= '0;
		end else if (accept) begin
			pos_q <= (p < POS_MAX) ? p + 10'd1 : POS_MAX;
			if (p == 10'd0) begin
				len_hi_q <= digit;
			end
			if (p == 10'd1) begin
				len_q <= {len_hi_q, digit};
			end
		end
	end

endmodule

/* rtl/hrp_fifo.sv */
// ----------------------------------------------------------------------------
// hrp_fifo
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hrp_fifo #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hrp_pkg::hrp_cmd_t push_data,
	output logic              full,
	input  logic              pop,
	output hrp_pkg::hrp_cmd_t pop_data,
	output logic              empty
);
	import hrp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CFULL = CW'(DEPTH);

	hrp_cmd_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CFULL);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/hrp_back.sv */
// ----------------------------------------------------------------------------
// hrp_back
// Executes classified characters: assembles header fields, the byte sum and
// the data words, and holds each result in an output register.
// ----------------------------------------------------------------------------
module hrp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  hrp_pkg::hrp_cmd_t cmd,
	output logic              pop,
	output logic              res_valid,
	output hrp_pkg::hrp_out_t res_word,
	input  logic              res_stall
);
	import hrp_pkg::*;

	logic [7:0]  byte_count_q;
	logic [15:0] load_address_q;
	logic [7:0]  type_byte_q;
	logic [7:0]  byte_sum_q;
	logic [3:0]  high_nibble_q;
	logic [31:0] word_acc_q;
	logic [5:0]  word_number_q;
	logic        res_valid_q;
	hrp_out_t    res_word_q;

	logic [7:0]  sum_base;
	logic [15:0] addr_base;
	logic [31:0] acc_base;
	logic [5:0]  wnum_base;
	logic [7:0]  b;
	logic [31:0] acc_next;
	logic [7:0]  neg_sum;

	assign pop       = cmd_valid && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	// A start mark clears the per-record state before the character is used.
	assign sum_base  = cmd.restart ? '0 : byte_sum_q;
	assign addr_base = cmd.restart ? '0 : load_address_q;
	assign acc_base  = cmd.restart ? '0 : word_acc_q;
	assign wnum_base = cmd.restart ? '0 : word_number_q;
	assign b         = {high_nibble_q, cmd.digit};
	assign acc_next  = {acc_base[27:0], cmd.digit};
	assign neg_sum   = 8'h00 - sum_base;

	// Record state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			load_address_q <= '0;
			type_byte_q    <= '0;
			byte_sum_q     <= '0;
			high_nibble_q  <= '0;
			word_acc_q     <= '0;
			word_number_q  <= '0;
		end else if (pop) begin
			byte_sum_q     <= sum_base;
			load_address_q <= addr_base;
			word_acc_q     <= acc_base;
			word_number_q  <= wnum_base;
			case (cmd.op)
				OP_HEADER: begin
					if (cmd.pidx >= 3'd2 && cmd.pidx <= 3'd5) begin
						load_address_q <= {addr_base[11:0], cmd.digit};
					end
					if (!cmd.pidx[0]) begin
						high_nibble_q <= cmd.digit;
					end else begin
						byte_sum_q <= sum_base + b;
						if (cmd.pidx == 3'd1) begin
							byte_count_q <= b;
						end
						if (cmd.pidx == 3'd7) begin
							type_byte_q <= b;
						end
					end
				end
				OP_DATA: begin
					word_acc_q <= acc_next;
					if (!cmd.pidx[0]) begin
						high_nibble_q <= cmd.digit;
					end else begin
						byte_sum_q <= sum_base + b;
					end
					if (cmd.pidx == 3'd7) begin
						word_number_q <= wnum_base + 6'd1;
					end
				end
				OP_CK_HIGH: begin
					high_nibble_q <= cmd.digit;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: loaded when a character completes a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && ((cmd.op == OP_DATA && cmd.pidx == 3'd7) ||
				cmd.op == OP_CK_LOW)) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.op == OP_DATA && cmd.pidx == 3'd7) begin
			res_word_q.kind         <= KIND_DATA;
			res_word_q.word_address <= {2'b00, addr_base[15:2]} + {10'd0, wnum_base};
			res_word_q.word_data    <= acc_next;
			res_word_q.record_type  <= '0;
			res_word_q.data_length  <= '0;
			res_word_q.checksum_ok  <= 1'b0;
		end else if (pop && cmd.op == OP_CK_LOW) begin
			res_word_q.kind         <= KIND_DONE;
			res_word_q.word_address <= '0;
			res_word_q.word_data    <= '0;
			res_word_q.record_type  <= type_byte_q;
			res_word_q.data_length  <= byte_count_q;
			res_word_q.checksum_ok  <= (b == neg_sum);
		end
	end

endmodule
